[src/htsb_pkg.sv]
// ============================================================================
// htsb_pkg: shared types and constants for the sorted-bucket hash table
// Table geometry, key reduction constants, status codes and the command
// group that the controller sends to the datapath.
// ============================================================================
package htsb_pkg;

    // Table geometry.
    localparam int NUM_BUCKETS  = 16;
    localparam int BUCKET_DEPTH = 8;

    // Fixed field widths.
    localparam int KEY_W    = 16;
    localparam int STATUS_W = 2;
    localparam int BOUT_W   = 4;

    // Derived widths.
    localparam int BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);

    // Key reduction by reciprocal multiplication. HASH_MULT rounds down
    // 2^HASH_SHIFT / NUM_BUCKETS, so the quotient is exact or one short and
    // the remainder estimate stays below twice the bucket count.
    localparam int HASH_SHIFT = KEY_W + BIDX_W;
    localparam int MULT_W     = KEY_W + 1;
    localparam int PROD_W     = KEY_W + MULT_W;
    localparam int QUO_W      = PROD_W - HASH_SHIFT;
    localparam int RED_W      = BIDX_W + 1;
    localparam logic [MULT_W-1:0] HASH_MULT =
        MULT_W'((64'd1 << HASH_SHIFT) / NUM_BUCKETS);
    localparam logic [RED_W-1:0] NB_RED = RED_W'(NUM_BUCKETS);

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [BOUT_W-1:0]   bucket_out_t;
    typedef logic [BIDX_W-1:0]   bidx_t;
    typedef logic [FILL_W-1:0]   fill_t;
    typedef logic [BUCKET_DEPTH-1:0][KEY_W-1:0] row_t;

    // Request kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Result status codes.
    localparam status_t ST_INSERTED  = 2'd0;
    localparam status_t ST_FOUND     = 2'd1;
    localparam status_t ST_NOT_FOUND = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture a new request and start the key reduction
        logic hash;   // finish the reduction and read the bucket row
        logic exec;   // compare, write the row back and load the result
    } cmd_t;

endpackage

[src/hash_table_sorted_buckets.sv]
// ============================================================================
// hash_table_sorted_buckets: hash table with sorted fixed-depth buckets
// Insert and search requests on 16-bit keys, bucketed by key modulo the
// bucket count, one result per request.
// ============================================================================
// A request (kind 0 insert, kind 1 search) is reduced to its bucket, that
// bucket's row is read from the row memory, compared against the key in
// parallel and, for an insert, written back with the key in sorted position.
// Each request yields one result: inserted, found, not found, or bucket full
// (the insert is refused and nothing changes). Results are held in an output
// register. A new request is taken only when idle or as the previous request
// writes its result, because of the read-modify-write of the single-port row
// memory. A new request may be taken while the previous result still waits
// in the output register. Bucket fill counts clear at reset, so the block is
// ready in the first cycle after reset.
module hash_table_sorted_buckets (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  htsb_pkg::key_t        key,
    output logic                  out_valid,
    input  logic                  out_ready,
    output htsb_pkg::status_t     status,
    output htsb_pkg::bucket_out_t bucket
);
    import htsb_pkg::*;

    cmd_t cmd;

    htsb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    htsb_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .kind   (kind),
        .key    (key),
        .status (status),
        .bucket (bucket)
    );

endmodule

[src/htsb_ctrl.sv]
// ============================================================================
// htsb_ctrl: request sequencer
// Walks each request through key reduction, row read and row update, and
// owns the input ready and the output valid register.
// ============================================================================
module htsb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output htsb_pkg::cmd_t cmd
);
    import htsb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;
    logic   accept;
    logic   exec_go;

    // The output register can take a new result when it is empty or its
    // transaction completes in this cycle.
    assign slot_free = !out_valid_reg || out_ready;
    assign exec_go   = (state_reg == S_EXEC) && slot_free;
    assign in_ready  = (state_reg == S_IDLE) || exec_go;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = accept ? S_HASH : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd.load  = accept;
    assign cmd.hash  = (state_reg == S_HASH);
    assign cmd.exec  = exec_go;

endmodule

[src/htsb_dp.sv]
// ============================================================================
// htsb_dp: bucket datapath
// Reduces the key to a bucket index, holds the bucket rows and fill counts,
// compares a row against the key in parallel and writes back the sorted row.
// ============================================================================
module htsb_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  htsb_pkg::cmd_t        cmd,
    input  logic                  kind,
    input  htsb_pkg::key_t        key,
    output htsb_pkg::status_t     status,
    output htsb_pkg::bucket_out_t bucket
);
    import htsb_pkg::*;

    // Request capture and reduction.
    logic                    kind_reg;
    key_t                    key_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       prod_next;
    logic [QUO_W-1:0]        quo;
    logic [RED_W-1:0]        rem_est;
    logic [RED_W-1:0]        rem_fix;
    bidx_t                   bidx_next;
    bidx_t                   bidx_reg;

    // Row memory and fill counts.
    row_t                    row_mem [NUM_BUCKETS];
    row_t                    row_rd_reg;
    fill_t                   fill_reg [NUM_BUCKETS];
    fill_t                   fill_cur;

    // Compare and update.
    logic [BUCKET_DEPTH-1:0] lt_vec;
    logic [BUCKET_DEPTH-1:0] eq_vec;
    logic                    row_full;
    logic                    do_write;
    row_t                    row_new;
    status_t                 status_next;
    logic [BIDX_W+BOUT_W-1:0] bidx_ext;

    // Result registers.
    status_t                 status_reg;
    bucket_out_t             bucket_reg;

    assign prod_next = PROD_W'(key) * PROD_W'(HASH_MULT);

    // Only the low bits of key - quotient * NUM_BUCKETS are needed, since the
    // estimate is known to be below twice the bucket count.
    assign quo       = prod_reg[PROD_W-1:HASH_SHIFT];
    assign rem_est   = key_reg[RED_W-1:0] - RED_W'(quo[RED_W-1:0] * NB_RED);
    assign rem_fix   = (rem_est >= NB_RED) ? (rem_est - NB_RED) : rem_est;
    assign bidx_next = rem_fix[BIDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            prod_reg <= prod_next;
        end
        if (cmd.hash)
        begin
            bidx_reg   <= bidx_next;
            row_rd_reg <= row_mem[bidx_next];
        end
        if (do_write)
        begin
            row_mem[bidx_reg] <= row_new;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            bucket_reg <= bidx_ext[BOUT_W-1:0];
        end
    end

    assign fill_cur = fill_reg[bidx_reg];
    assign row_full = (fill_cur == FILL_W'(BUCKET_DEPTH));
    assign do_write = cmd.exec && (kind_reg == KIND_INSERT) && !row_full;

    // Rows are sorted, so the entries below the key form a prefix and the
    // new key goes right after that prefix.
    always_comb
    begin
        for (int i = 0; i < BUCKET_DEPTH; i++)
        begin
            lt_vec[i] = (FILL_W'(i) < fill_cur) && (row_rd_reg[i] < key_reg);
            eq_vec[i] = (FILL_W'(i) < fill_cur) && (row_rd_reg[i] == key_reg);
        end
        for (int i = 0; i < BUCKET_DEPTH; i++)
        begin
            if (lt_vec[i])
            begin
                row_new[i] = row_rd_reg[i];
            end
            else if (i == 0)
            begin
                row_new[i] = key_reg;
            end
            else if (lt_vec[i-1])
            begin
                row_new[i] = key_reg;
            end
            else
            begin
                row_new[i] = row_rd_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (kind_reg == KIND_INSERT)
        begin
            status_next = row_full ? ST_FULL : ST_INSERTED;
        end
        else
        begin
            status_next = (|eq_vec) ? ST_FOUND : ST_NOT_FOUND;
        end
    end

    assign bidx_ext = {{BOUT_W{1'b0}}, bidx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else if (do_write)
        begin
            fill_reg[bidx_reg] <= FILL_W'(fill_cur + 1'b1);
        end
    end

    assign status = status_reg;
    assign bucket = bucket_reg;

endmodule
